// ----- design/ttem_pkg.sv -----
// ttem_pkg: shared types, constants and helper functions for the timestamp text decoder
// used by ttem_front, ttem_queue, ttem_back and timestamp_text_to_epoch_ms_core
package ttem_pkg;

  localparam int MAX_PLAIN_DIGITS_DEF = 13;
  localparam int EPOCH_W     = 54;
  localparam int POS_COUNT   = 14;
  localparam int POS_W       = 9;
  localparam int DT_MIN_LEN  = 19;
  localparam int SEP_INDEX   = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    FMT_DIGITS   = 2'd0,
    FMT_DATETIME = 2'd1,
    FMT_NONE     = 2'd2,
    FMT_MONTH    = 2'd3
  } fmt_t;

  typedef logic signed [POS_W-1:0] pos_t;

  // one finished text, handed from front to back
  typedef struct packed {
    fmt_t                              kind;
    logic [EPOCH_W-1:0]                plain;
    logic [POS_COUNT-1:0][POS_W-1:0]   pos;
  } rec_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } slot_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAIR,
    BK_DATE,
    BK_DAYS,
    BK_SECS,
    BK_MSEC,
    BK_OUT
  } back_state_t;

  // bits needed to hold n decimal digits, at least 4 and capped at the result width
  function automatic int plain_width(input int n);
    longint unsigned v;
    int w;
    v = 1;
    for (int i = 0; i < n; i++) v = v * 10;
    w = $clog2(v);
    if (w > EPOCH_W) w = EPOCH_W;
    if (w < 4) w = 4;
    return w;
  endfunction

  // character index to date digit slot, separators have no slot
  function automatic slot_t slot_of(input logic [4:0] idx);
    slot_t s;
    s.hit  = 1'b1;
    s.slot = 4'd0;
    case (idx)
      5'd0:  s.slot = 4'd0;
      5'd1:  s.slot = 4'd1;
      5'd2:  s.slot = 4'd2;
      5'd3:  s.slot = 4'd3;
      5'd5:  s.slot = 4'd4;
      5'd6:  s.slot = 4'd5;
      5'd8:  s.slot = 4'd6;
      5'd9:  s.slot = 4'd7;
      5'd11: s.slot = 4'd8;
      5'd12: s.slot = 4'd9;
      5'd14: s.slot = 4'd10;
      5'd15: s.slot = 4'd11;
      5'd17: s.slot = 4'd12;
      5'd18: s.slot = 4'd13;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

  // days before the first of the month, month given from zero
  function automatic logic [8:0] cum_days(input logic [3:0] m0);
    logic [8:0] d;
    case (m0)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd59;
      4'd3:  d = 9'd90;
      4'd4:  d = 9'd120;
      4'd5:  d = 9'd151;
      4'd6:  d = 9'd181;
      4'd7:  d = 9'd212;
      4'd8:  d = 9'd243;
      4'd9:  d = 9'd273;
      4'd10: d = 9'd304;
      4'd11: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // two digit positions combined as tens and units
  function automatic logic signed [12:0] pair_val(input pos_t a, input pos_t b);
    logic signed [12:0] ax;
    logic signed [12:0] bx;
    ax = 13'(a);
    bx = 13'(b);
    return ax * 13'sd10 + bx;
  endfunction

endpackage

// ----- design/ttem_front.sv -----
// ttem_front: takes text bytes, keeps the running digit total and date positions,
// and hands one classified record per text to the queue; depends on ttem_pkg
module ttem_front #(
  parameter int MAX_PLAIN_DIGITS = ttem_pkg::MAX_PLAIN_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tuser,
  input  logic          s_tlast,
  output ttem_pkg::rec_t rec,
  output logic          rec_valid,
  input  logic          rec_ready
);
  import ttem_pkg::*;

  localparam int DIGIT_W = plain_width(MAX_PLAIN_DIGITS);

  logic [4:0]                      char_count;
  logic                            only_digits;
  logic [DIGIT_W-1:0]              digit_total;
  logic [POS_COUNT-1:0][POS_W-1:0] pos;
  logic                            sep_ok;

  logic [4:0]                      char_count_next;
  logic                            only_digits_next;
  logic [DIGIT_W-1:0]              digit_total_next;
  logic [POS_COUNT-1:0][POS_W-1:0] pos_next;
  logic                            sep_ok_next;

  logic  accept;
  logic  is_digit;
  slot_t slot;

  assign s_tready = rec_ready;
  assign accept   = s_tvalid && s_tready;
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign slot     = slot_of(char_count);

  always_comb begin
    char_count_next  = char_count;
    only_digits_next = only_digits;
    digit_total_next = digit_total;
    pos_next         = pos;
    sep_ok_next      = sep_ok;
    if (s_tuser) begin
      if (!is_digit) begin
        only_digits_next = 1'b0;
      end else if (char_count < 5'(MAX_PLAIN_DIGITS)) begin
        digit_total_next = (digit_total << 3) + (digit_total << 1)
                         + DIGIT_W'(s_tdata[3:0]);
      end
      if (slot.hit) begin
        pos_next[slot.slot] = {1'b0, s_tdata} - 9'd48;
      end
      if (char_count == 5'(SEP_INDEX)) begin
        sep_ok_next = (s_tdata == CH_T) || (s_tdata == CH_SPACE);
      end
      if (char_count != 5'd31) begin
        char_count_next = char_count + 5'd1;
      end
    end
  end

  // classification of the text as it stands after this byte
  always_comb begin
    rec.plain = EPOCH_W'(digit_total_next);
    rec.pos   = pos_next;
    if ((char_count_next != 5'd0) && only_digits_next
        && (char_count_next <= 5'(MAX_PLAIN_DIGITS))) begin
      rec.kind = FMT_DIGITS;
    end else if ((char_count_next >= 5'(DT_MIN_LEN)) && sep_ok_next) begin
      rec.kind = FMT_DATETIME;
    end else begin
      rec.kind = FMT_NONE;
    end
  end

  assign rec_valid = accept && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count  <= '0;
      only_digits <= 1'b1;
      digit_total <= '0;
      sep_ok      <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        char_count  <= '0;
        only_digits <= 1'b1;
        digit_total <= '0;
        sep_ok      <= 1'b0;
      end else begin
        char_count  <= char_count_next;
        only_digits <= only_digits_next;
        digit_total <= digit_total_next;
        sep_ok      <= sep_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= pos_next;
    end
  end

endmodule

// ----- design/ttem_queue.sv -----
// ttem_queue: short record queue between the character front and the date back end
// depends on ttem_pkg
module ttem_queue (
  input  logic           clk,
  input  logic           rst,
  input  ttem_pkg::rec_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output ttem_pkg::rec_t rd_data,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import ttem_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  rec_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/ttem_back.sv -----
// ttem_back: date and time arithmetic sequencer plus the result output register
// depends on ttem_pkg, fed by ttem_queue
module ttem_back (
  input  logic           clk,
  input  logic           rst,
  input  ttem_pkg::rec_t rd_data,
  input  logic           rd_valid,
  output logic           rd_ready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [55:0]    m_tdata,
  output logic [1:0]     m_tuser
);
  import ttem_pkg::*;

  back_state_t state, state_next;

  rec_t                    work, work_next;
  logic signed [12:0]      pr [7];
  logic signed [12:0]      pr_next [7];
  logic signed [18:0]      year, year_next;
  logic signed [27:0]      days, days_next;
  logic signed [24:0]      tod, tod_next;
  logic signed [45:0]      secs, secs_next;
  logic [EPOCH_W-1:0]      res_ms, res_ms_next;
  fmt_t                    res_st, res_st_next;

  logic [EPOCH_W-1:0]      out_ms;
  fmt_t                    out_st;
  logic                    out_load;

  logic signed [27:0]      yq;
  logic signed [27:0]      yq_adj;
  logic signed [27:0]      div4;
  logic                    leap;
  logic [3:0]              mon0;
  logic signed [55:0]      ms_full;

  always_comb begin
    yq     = 28'(year) - 28'sd1969;
    yq_adj = yq + (yq[27] ? 28'sd3 : 28'sd0);
    div4   = yq_adj >>> 2;
    leap   = (pr[2] > 13'sd2) && (year[1:0] == 2'b00);
    mon0   = pr[2][3:0] - 4'd1;
    ms_full = 56'(secs) * 56'sd1000;
  end

  always_comb begin
    state_next  = state;
    work_next   = work;
    pr_next     = pr;
    year_next   = year;
    days_next   = days;
    tod_next    = tod;
    secs_next   = secs;
    res_ms_next = res_ms;
    res_st_next = res_st;
    rd_ready    = 1'b0;
    out_load    = 1'b0;
    case (state)
      BK_IDLE: begin
        rd_ready = 1'b1;
        if (rd_valid) begin
          work_next   = rd_data;
          res_st_next = rd_data.kind;
          res_ms_next = (rd_data.kind == FMT_DIGITS) ? rd_data.plain : '0;
          state_next  = (rd_data.kind == FMT_DATETIME) ? BK_PAIR : BK_OUT;
        end
      end
      BK_PAIR: begin
        for (int i = 0; i < 7; i++) begin
          pr_next[i] = pair_val(work.pos[2*i], work.pos[2*i+1]);
        end
        state_next = BK_DATE;
      end
      BK_DATE: begin
        year_next = 19'(pr[0]) * 19'sd100 + 19'(pr[1]);
        if ((pr[2] < 13'sd1) || (pr[2] > 13'sd12)) begin
          res_ms_next = '0;
          res_st_next = FMT_MONTH;
          state_next  = BK_OUT;
        end else begin
          state_next = BK_DAYS;
        end
      end
      BK_DAYS: begin
        days_next = (28'(year) - 28'sd1970) * 28'sd365 + div4
                  + $signed({19'b0, cum_days(mon0)}) + 28'(pr[3]) - 28'sd1
                  + (leap ? 28'sd1 : 28'sd0);
        tod_next  = 25'(pr[4]) * 25'sd3600 + 25'(pr[5]) * 25'sd60 + 25'(pr[6]);
        state_next = BK_SECS;
      end
      BK_SECS: begin
        secs_next  = 46'(days) * 46'sd86400 + 46'(tod);
        state_next = BK_MSEC;
      end
      BK_MSEC: begin
        res_ms_next = ms_full[EPOCH_W-1:0];
        res_st_next = FMT_DATETIME;
        state_next  = BK_OUT;
      end
      BK_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    work   <= work_next;
    pr     <= pr_next;
    year   <= year_next;
    days   <= days_next;
    tod    <= (state == BK_DAYS) ? tod_next : tod;
    secs   <= secs_next;
    res_ms <= res_ms_next;
    res_st <= res_st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ms <= res_ms;
      out_st <= res_st;
    end
  end

  assign m_tdata = {2'b00, out_ms};
  assign m_tuser = out_st;

endmodule

// ----- design/timestamp_text_to_epoch_ms_core.sv -----
// timestamp_text_to_epoch_ms_core: top level of the timestamp text decoder
// depends on ttem_pkg, ttem_front, ttem_queue and ttem_back
//
// usage:
//   input stream (s_*): one text byte per transfer; s_tdata = char_code,
//   s_tuser = has_char (0 only to end an empty text), s_tlast = end of text
//   output stream (m_*): one result per text; m_tdata[53:0] = epoch_ms
//   (signed milliseconds since 1970), m_tuser = format_status
//   (0 digits, 1 date-time, 2 unrecognized or empty, 3 month out of range)
// throughput: one byte per cycle while s_tready is high; the back end takes a
//   new record only from idle and steps a date-time text through its date
//   sequencer (pairs, year, days, seconds, milliseconds), a month out of range
//   only through pairs and year, so short texts can fill the two-entry record
//   queue and then hold s_tready low
// path: the last byte of a text becomes a record in the queue; the back end
//   takes it when idle and, after its sequencer steps, loads the output register
//   once that register is free (m_tvalid low or m_tready high)
// stalls: the output register holds its result while m_tready is low; the
//   front keeps taking bytes until the queue is full
// reset: rst clears the text state, the queue, the back end state and the output valid
module timestamp_text_to_epoch_ms_core #(
  parameter int MAX_PLAIN_DIGITS = ttem_pkg::MAX_PLAIN_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic        s_tuser,   // has_char
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // epoch_ms[53:0], zero pad [55:54]
  output logic [1:0]  m_tuser    // format_status[1:0]
);
  import ttem_pkg::*;

  // records from front to queue
  rec_t front_rec;
  logic front_valid;
  logic front_ready;

  // records from queue to back end
  rec_t queue_rec;
  logic queue_valid;
  logic queue_ready;

  // byte intake, running digit total and date positions
  ttem_front #(
    .MAX_PLAIN_DIGITS(MAX_PLAIN_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .rec       (front_rec),
    .rec_valid (front_valid),
    .rec_ready (front_ready)
  );

  // decouples the byte stream from the date arithmetic
  ttem_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_rec),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_data  (queue_rec),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  // date arithmetic and output register
  ttem_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_data  (queue_rec),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
